// ===== rtl/rsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_pkg
// Shared types and codes for the register stack machine execute block.
// ----------------------------------------------------------------------------
package rsm_pkg;

    // Program length; the 9-bit index saturates here at the end of program.
    localparam int PROGRAM_DEPTH = 256;

    typedef enum logic [3:0] {
        ACT_MOV   = 4'd0,
        ACT_ADD   = 4'd1,
        ACT_SUB   = 4'd2,
        ACT_MUL   = 4'd3,
        ACT_DIV   = 4'd4,
        ACT_PRINT = 4'd5,
        ACT_JMP   = 4'd6,
        ACT_IF    = 4'd7,
        ACT_PUSH  = 4'd8,
        ACT_POP   = 4'd9,
        ACT_CALL  = 4'd10,
        ACT_RET   = 4'd11,
        ACT_LABEL = 4'd12
    } t_action;

    typedef enum logic [2:0] {
        CMP_GT = 3'd0,
        CMP_LT = 3'd1,
        CMP_EQ = 3'd2,
        CMP_NE = 3'd3,
        CMP_GE = 3'd4,
        CMP_LE = 3'd5
    } t_cmp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_STACK,
        ST_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;        // capture instruction, read operands
        logic exec;        // single-cycle commit
        logic div_start;
        logic div_step;
        logic div_done;    // commit quotient
        logic stack_done;  // commit pop or ret after stack read
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_div;
        logic is_stack_read;
        logic div_last;
    } t_status;

endpackage

// ===== rtl/rsm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/rsm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_ctrl
// Sequencer: accept, execute, iterate division or stack read, deliver.
// ----------------------------------------------------------------------------
module rsm_ctrl
    import rsm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else if (i_status.is_stack_read) begin
                    n_state = ST_STACK;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_OUT;
                end
            end
            ST_DIV: begin
                if (i_status.div_last) begin
                    o_cmd.div_done = 1'b1;
                    n_state        = ST_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            ST_STACK: begin
                o_cmd.stack_done = 1'b1;
                n_state          = ST_OUT;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall)
        else $error("input accepted while busy");
    a_one_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.exec, o_cmd.div_done, o_cmd.stack_done}))
        else $error("multiple commits");
    a_out_after_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.exec || o_cmd.div_done || o_cmd.stack_done) |=> o_valid)
        else $error("result not presented after commit");
`endif
endmodule

// ===== rtl/rsm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_dp
// Datapath: register file, stack memory, ALU, iterative divider, index.
// ----------------------------------------------------------------------------
module rsm_dp
    import rsm_pkg::*;
#(
    parameter int REGISTER_COUNT = 16,
    parameter int STACK_DEPTH    = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [3:0]         i_action,
    input  logic [3:0]         i_first_reg,
    input  logic [3:0]         i_second_reg,
    input  logic               i_first_is_imm,
    input  logic signed [31:0] i_first_imm,
    input  logic               i_second_is_imm,
    input  logic signed [31:0] i_second_imm,
    input  logic [2:0]         i_compare_kind,
    input  logic [7:0]         i_target_index,
    input  logic               i_target_known,
    output logic [8:0]         o_next_index,
    output logic signed [31:0] o_print_value,
    output logic               o_print_valid,
    output logic               o_div_zero_halt,
    output logic               o_stack_full
);
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int IW  = 9;
    localparam logic [IW-1:0] PEND = IW'(PROGRAM_DEPTH);

    // Instruction registers.
    logic [3:0]  r_act;
    logic [3:0]  r_ra;
    logic        r_fimm_sel, r_simm_sel, r_known;
    logic [31:0] r_fimm, r_simm;
    logic [2:0]  r_kind;
    logic [7:0]  r_tgt;
    logic [31:0] r_a, r_b;
    logic        r_run;   // machine live at load time

    logic [31:0] r_regs [REGISTER_COUNT];
    logic [SCW-1:0] r_sp;
    logic [IW-1:0]  r_idx;
    logic           r_halt;

    logic [31:0] rd_a, rd_b;
    always_comb begin
        rd_a = '0;
        rd_b = '0;
        for (int k = 0; k < REGISTER_COUNT; k++) begin
            if (32'(i_first_reg) == 32'(k)) rd_a = r_regs[k];
            if (32'(i_second_reg) == 32'(k)) rd_b = r_regs[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act      <= i_action;
            r_ra       <= i_first_reg;
            r_fimm_sel <= i_first_is_imm;
            r_simm_sel <= i_second_is_imm;
            r_fimm     <= i_first_imm;
            r_simm     <= i_second_imm;
            r_kind     <= i_compare_kind;
            r_tgt      <= i_target_index;
            r_known    <= i_target_known;
            r_a        <= rd_a;
            r_b        <= rd_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_cmd.load) begin
            r_run <= !r_halt && (r_idx < PEND);
        end
    end

    // Stack RAM.
    logic            ram_we;
    logic [SAW-1:0]  ram_waddr, ram_raddr;
    logic [31:0]     ram_wdata, ram_rdata;
    logic [SCW-1:0]  sp_dec;
    assign sp_dec    = r_sp - SCW'(1);
    assign ram_raddr = sp_dec[SAW-1:0];

    rsm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Divider: restoring, magnitudes, one bit per cycle.
    logic [31:0] r_dq, r_dr, r_dd;
    logic [5:0]  r_dcnt;
    logic        r_dneg;
    logic [32:0] dtrial;
    assign dtrial = {r_dr, r_dq[31]} - {1'b0, r_dd};

    logic [IW-1:0] adv;
    assign adv = (r_idx >= PEND) ? PEND : r_idx + IW'(1);

    logic signed [31:0] cl, cr;
    logic cmp_t;
    always_comb begin
        cl = r_fimm_sel ? r_fimm : r_a;
        cr = r_simm_sel ? r_simm : r_b;
        case (r_kind)
            CMP_GT:  cmp_t = cl > cr;
            CMP_LT:  cmp_t = cl < cr;
            CMP_EQ:  cmp_t = cl == cr;
            CMP_NE:  cmp_t = cl != cr;
            CMP_GE:  cmp_t = cl >= cr;
            CMP_LE:  cmp_t = cl <= cr;
            default: cmp_t = 1'b0;
        endcase
    end

    logic live_div, live_sr, sp_has, sp_room;
    assign sp_has  = (r_sp != '0);
    assign sp_room = (r_sp < SCW'(STACK_DEPTH));
    assign live_div = r_run && (r_act == ACT_DIV) && (r_b != '0);
    assign live_sr  = r_run && sp_has && ((r_act == ACT_POP) || (r_act == ACT_RET));
    assign o_status.is_div        = live_div;
    assign o_status.is_stack_read = live_sr;
    assign o_status.div_last      = (r_dcnt == 6'd32);

    logic [31:0]   wr_val;
    logic          wr_en;
    logic [IW-1:0] n_idx;
    logic          n_pv, n_full, n_halt;
    logic [31:0]   n_pval;
    logic [SCW-1:0] n_sp;
    logic [31:0]   mulp;
    assign mulp = r_a * r_b;

    always_comb begin
        wr_en     = 1'b0;
        wr_val    = '0;
        n_idx     = r_idx;
        n_pv      = 1'b0;
        n_pval    = '0;
        n_full    = 1'b0;
        n_halt    = r_halt;
        n_sp      = r_sp;
        ram_we    = 1'b0;
        ram_waddr = r_sp[SAW-1:0];
        ram_wdata = r_a;
        if (i_cmd.exec && r_run) begin
            n_idx = adv;
            case (r_act)
                ACT_MOV: begin wr_en = 1'b1; wr_val = r_simm_sel ? r_simm : r_b; end
                ACT_ADD: begin wr_en = 1'b1; wr_val = r_a + r_b; end
                ACT_SUB: begin wr_en = 1'b1; wr_val = r_a - r_b; end
                ACT_MUL: begin wr_en = 1'b1; wr_val = mulp; end
                ACT_DIV: begin n_halt = 1'b1; n_idx = r_idx; end
                ACT_PRINT: begin n_pv = 1'b1; n_pval = r_a; end
                ACT_JMP: if (r_known) n_idx = IW'(r_tgt);
                ACT_IF: if (cmp_t && r_known) n_idx = IW'(r_tgt);
                ACT_PUSH: begin
                    if (sp_room) begin
                        ram_we = 1'b1;
                        n_sp   = r_sp + SCW'(1);
                    end else begin
                        n_full = 1'b1;
                    end
                end
                ACT_CALL: begin
                    if (r_known) begin
                        if (sp_room) begin
                            ram_we    = 1'b1;
                            ram_wdata = 32'(adv);
                            n_sp      = r_sp + SCW'(1);
                        end else begin
                            n_full = 1'b1;
                        end
                        n_idx = IW'(r_tgt);
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.div_done) begin
            n_idx  = adv;
            wr_en  = 1'b1;
            wr_val = r_dneg ? -r_dq : r_dq;
        end
        if (i_cmd.stack_done) begin
            n_idx = adv;
            n_sp  = sp_dec;
            if (r_act == ACT_POP) begin
                wr_en  = 1'b1;
                wr_val = ram_rdata;
            end else begin
                n_idx = (ram_rdata < 32'(PROGRAM_DEPTH)) ? IW'(ram_rdata) : PEND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REGISTER_COUNT; k++) r_regs[k] <= '0;
            r_sp   <= '0;
            r_idx  <= '0;
            r_halt <= 1'b0;
        end else begin
            if (wr_en && (32'(r_ra) < 32'(REGISTER_COUNT))) begin
                r_regs[r_ra[$clog2(REGISTER_COUNT)-1:0]] <= wr_val;
            end
            r_sp   <= n_sp;
            r_idx  <= n_idx;
            r_halt <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dq   <= r_a[31] ? -r_a : r_a;
            r_dd   <= r_b[31] ? -r_b : r_b;
            r_dr   <= '0;
            r_dcnt <= '0;
            r_dneg <= r_a[31] ^ r_b[31];
        end else if (i_cmd.div_step) begin
            if (!dtrial[32]) begin
                r_dr <= dtrial[31:0];
                r_dq <= {r_dq[30:0], 1'b1};
            end else begin
                r_dr <= {r_dr[30:0], r_dq[31]};
                r_dq <= {r_dq[30:0], 1'b0};
            end
            r_dcnt <= r_dcnt + 6'd1;
        end
    end

    // Result register.
    logic r_commit;
    assign r_commit = i_cmd.exec || i_cmd.div_done || i_cmd.stack_done;
    always_ff @(posedge i_clk) begin
        if (r_commit) begin
            o_next_index    <= n_idx;
            o_print_value   <= n_pval;
            o_print_valid   <= n_pv;
            o_div_zero_halt <= n_halt;
            o_stack_full    <= n_full;
        end
    end

`ifndef ASSERT_OFF
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SCW'(STACK_DEPTH))
        else $error("stack count overflow");
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt cleared");
    a_halt_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> $stable(r_idx))
        else $error("index moved while halted");
`endif
endmodule

// ===== rtl/register_stack_machine_execute.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_stack_machine_execute
// Executes one decoded instruction per transfer on a register/stack machine.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | i_valid / o_stall    | action .. target_known
//  out     | output    | o_valid / i_stall    | next_index .. stack_full
//
//  One instruction at a time. Most pass through load, execute and present;
//  pop and ret on a non-empty stack add a stack memory read before the
//  commit; a div with nonzero divisor iterates the restoring divider, one
//  quotient bit per cycle.
//  Reset (synchronous, active low) clears registers, stack count, index and
//  halt. A stalled result holds its register; no new transfer is taken until
//  the result is delivered.
// ----------------------------------------------------------------------------
module register_stack_machine_execute
    import rsm_pkg::*;
#(
    parameter int REGISTER_COUNT = 16,
    parameter int STACK_DEPTH    = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_action,
    input  logic [3:0]         i_first_reg,
    input  logic [3:0]         i_second_reg,
    input  logic               i_first_is_imm,
    input  logic signed [31:0] i_first_imm,
    input  logic               i_second_is_imm,
    input  logic signed [31:0] i_second_imm,
    input  logic [2:0]         i_compare_kind,
    input  logic [7:0]         i_target_index,
    input  logic               i_target_known,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [8:0]         o_next_index,
    output logic signed [31:0] o_print_value,
    output logic               o_print_valid,
    output logic               o_div_zero_halt,
    output logic               o_stack_full
);
    t_cmd    cmd;
    t_status status;

    // Sequence each instruction.
    rsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_status(status),
        .o_cmd   (cmd)
    );

    // Hold the machine state and compute results.
    rsm_dp #(
        .REGISTER_COUNT(REGISTER_COUNT),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_action       (i_action),
        .i_first_reg    (i_first_reg),
        .i_second_reg   (i_second_reg),
        .i_first_is_imm (i_first_is_imm),
        .i_first_imm    (i_first_imm),
        .i_second_is_imm(i_second_is_imm),
        .i_second_imm   (i_second_imm),
        .i_compare_kind (i_compare_kind),
        .i_target_index (i_target_index),
        .i_target_known (i_target_known),
        .o_next_index   (o_next_index),
        .o_print_value  (o_print_value),
        .o_print_valid  (o_print_valid),
        .o_div_zero_halt(o_div_zero_halt),
        .o_stack_full   (o_stack_full)
    );
endmodule

// ===== bench/register_stack_machine_execute_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_stack_machine_execute_test
// Self-checking bench: drives decoded instructions with random bursts and
// gaps, stalls the result side on its own pattern, and checks every result
// against a machine-state predictor kept in the bench.
// ----------------------------------------------------------------------------
module register_stack_machine_execute_test;
    import rsm_pkg::*;

    localparam int NUM_REGS     = 16;
    localparam int STACK_SLOTS  = 64;
    localparam int PROG_END     = 256;
    // Index at which the generator forces a jump back, so the program
    // never runs off its end before the planned halt.
    localparam int WRAP_INDEX   = 240;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        logic [3:0]         action;
        logic [3:0]         first_reg;
        logic [3:0]         second_reg;
        logic               first_is_imm;
        logic signed [31:0] first_imm;
        logic               second_is_imm;
        logic signed [31:0] second_imm;
        logic [2:0]         compare_kind;
        logic [7:0]         target_index;
        logic               target_known;
        logic               hold;   // wait for every result before sending
    } t_instr;

    typedef struct {
        logic [8:0]         next_index;
        logic signed [31:0] print_value;
        logic               print_valid;
        logic               div_zero_halt;
        logic               stack_full;
    } t_outcome;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [3:0]         i_action = '0;
    logic [3:0]         i_first_reg = '0;
    logic [3:0]         i_second_reg = '0;
    logic               i_first_is_imm = 1'b0;
    logic signed [31:0] i_first_imm = '0;
    logic               i_second_is_imm = 1'b0;
    logic signed [31:0] i_second_imm = '0;
    logic [2:0]         i_compare_kind = '0;
    logic [7:0]         i_target_index = '0;
    logic               i_target_known = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [8:0]         o_next_index;
    logic signed [31:0] o_print_value;
    logic               o_print_valid;
    logic               o_div_zero_halt;
    logic               o_stack_full;

    register_stack_machine_execute u_top (.*);

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state
    // ------------------------------------------------------------------
    logic signed [31:0] mach_regs [NUM_REGS];
    logic [31:0]        mach_stack [STACK_SLOTS];
    int unsigned        mach_depth;
    logic [8:0]         mach_index;
    logic               mach_halted;

    t_instr   program_q [$];
    t_outcome expected_q [$];

    int n_issued   = 0;
    int n_accepted = 0;
    int n_done     = 0;
    int n_errors   = 0;
    bit stim_ready = 1'b0;

    function automatic logic [8:0] step_index(logic [8:0] idx);
        return (idx >= PROG_END) ? 9'(PROG_END) : idx + 9'd1;
    endfunction

    function automatic bit compare_holds(logic [2:0] kind, logic signed [31:0] l,
                                         logic signed [31:0] r);
        case (kind)
            CMP_GT:  return l > r;
            CMP_LT:  return l < r;
            CMP_EQ:  return l == r;
            CMP_NE:  return l != r;
            CMP_GE:  return l >= r;
            CMP_LE:  return l <= r;
            default: return 1'b0;
        endcase
    endfunction

    // Advance the machine by one instruction and return what it shows.
    function automatic t_outcome execute_instr(t_instr it);
        t_outcome           res;
        logic signed [31:0] a, b, l, r;
        logic [8:0]         nxt;
        res = '{default: '0};
        nxt = mach_index;
        if (!mach_halted && mach_index < PROG_END) begin
            a = mach_regs[it.first_reg];
            b = mach_regs[it.second_reg];
            nxt = step_index(mach_index);
            case (it.action)
                ACT_MOV: mach_regs[it.first_reg] = it.second_is_imm ? it.second_imm : b;
                ACT_ADD: mach_regs[it.first_reg] = a + b;
                ACT_SUB: mach_regs[it.first_reg] = a - b;
                ACT_MUL: mach_regs[it.first_reg] = a * b;
                ACT_DIV: begin
                    if (b == 0) begin
                        mach_halted = 1'b1;
                        nxt = mach_index;
                    end else if (b == -1) begin
                        mach_regs[it.first_reg] = -a;   // wraps for the most negative
                    end else begin
                        mach_regs[it.first_reg] = a / b;
                    end
                end
                ACT_PRINT: begin
                    res.print_value = a;
                    res.print_valid = 1'b1;
                end
                ACT_JMP: if (it.target_known) nxt = 9'(it.target_index);
                ACT_IF: begin
                    l = it.first_is_imm ? it.first_imm : a;
                    r = it.second_is_imm ? it.second_imm : b;
                    if (compare_holds(it.compare_kind, l, r) && it.target_known)
                        nxt = 9'(it.target_index);
                end
                ACT_PUSH: begin
                    if (mach_depth < STACK_SLOTS) begin
                        mach_stack[mach_depth] = a;
                        mach_depth++;
                    end else begin
                        res.stack_full = 1'b1;
                    end
                end
                ACT_POP: begin
                    if (mach_depth > 0) begin
                        mach_depth--;
                        mach_regs[it.first_reg] = mach_stack[mach_depth];
                    end
                end
                ACT_CALL: begin
                    if (it.target_known) begin
                        if (mach_depth < STACK_SLOTS) begin
                            mach_stack[mach_depth] = 32'(step_index(mach_index));
                            mach_depth++;
                        end else begin
                            res.stack_full = 1'b1;
                        end
                        nxt = 9'(it.target_index);
                    end
                end
                ACT_RET: begin
                    if (mach_depth > 0) begin
                        mach_depth--;
                        nxt = (mach_stack[mach_depth] < PROG_END) ?
                              9'(mach_stack[mach_depth]) : 9'(PROG_END);
                    end
                end
                default: ;
            endcase
            mach_index = nxt;
        end
        res.next_index    = nxt;
        res.div_zero_halt = mach_halted;
        return res;
    endfunction

    function automatic t_instr blank_instr(logic [3:0] act);
        t_instr it;
        it = '{default: '0};
        it.action = act;
        return it;
    endfunction

    // Queue one instruction and its prediction. Unless a halt is wanted,
    // steer clear of the terminal cases: division by zero, running off the
    // program end, and a return to an out-of-range index.
    task automatic emit(t_instr it, bit allow_end = 1'b0);
        t_instr back;
        if (!allow_end) begin
            if (mach_index >= WRAP_INDEX) begin
                back = blank_instr(ACT_JMP);
                back.target_known = 1'b1;
                back.target_index = 8'($urandom_range(0, 100));
                program_q  = {program_q, back};
                expected_q = {expected_q, execute_instr(back)};
            end
            if (it.action == ACT_DIV && mach_regs[it.second_reg] == 0)
                it.action = ACT_ADD;
            if (it.action == ACT_RET && mach_depth > 0 &&
                mach_stack[mach_depth - 1] >= WRAP_INDEX)
                it.action = ACT_POP;
            if ((it.action == ACT_JMP || it.action == ACT_IF || it.action == ACT_CALL) &&
                it.target_index >= WRAP_INDEX)
                it.target_index = 8'($urandom_range(0, WRAP_INDEX - 1));
        end
        program_q  = {program_q, it};
        expected_q = {expected_q, execute_instr(it)};
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return -32'sd1;
            3:       return 32'($urandom_range(0, 9));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_instr random_instr();
        t_instr it;
        it.action        = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                                        : 4'($urandom_range(0, 12));
        it.first_reg     = 4'($urandom);
        it.second_reg    = 4'($urandom);
        it.first_is_imm  = 1'($urandom);
        it.first_imm     = pick_value();
        it.second_is_imm = 1'($urandom);
        it.second_imm    = pick_value();
        it.compare_kind  = 3'($urandom);
        it.target_index  = 8'($urandom);
        it.target_known  = ($urandom_range(0, 4) != 0);
        it.hold          = ($urandom_range(0, 99) == 0);
        return it;
    endfunction

    task automatic emit_mov(logic [3:0] rd, logic signed [31:0] v);
        t_instr it;
        it = blank_instr(ACT_MOV);
        it.first_reg = rd;
        it.second_is_imm = 1'b1;
        it.second_imm = v;
        emit(it);
    endtask

    task automatic emit_op(logic [3:0] act, logic [3:0] ra, logic [3:0] rb);
        t_instr it;
        it = blank_instr(act);
        it.first_reg = ra;
        it.second_reg = rb;
        emit(it);
    endtask

    task automatic emit_branch(logic [3:0] act, logic [2:0] kind, logic known,
                               logic [7:0] tgt);
        t_instr it;
        it = blank_instr(act);
        it.first_is_imm = 1'b1;
        it.first_imm = 32'sd5;
        it.second_is_imm = 1'b1;
        it.second_imm = 32'sd5;
        it.compare_kind = kind;
        it.target_known = known;
        it.target_index = tgt;
        emit(it);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : build_program
        t_instr it;
        foreach (mach_regs[k]) mach_regs[k] = '0;
        mach_depth  = 0;
        mach_index  = '0;
        mach_halted = 1'b0;

        // Directed: overflow, extreme division, every operation and compare.
        emit_mov(4'd1, 32'sh7fffffff);
        emit_mov(4'd2, 32'sd1);
        emit_op(ACT_ADD, 4'd1, 4'd2);
        emit_mov(4'd3, 32'sh80000000);
        emit_mov(4'd4, -32'sd1);
        emit_op(ACT_DIV, 4'd3, 4'd4);
        emit_op(ACT_SUB, 4'd3, 4'd2);
        emit_op(ACT_MUL, 4'd1, 4'd1);
        emit_op(ACT_PRINT, 4'd3, 4'd0);
        emit_op(ACT_MOV, 4'd15, 4'd4);
        emit_branch(ACT_JMP, CMP_GT, 1'b0, 8'd200);
        emit_branch(ACT_JMP, CMP_GT, 1'b1, 8'd30);
        for (int k = 0; k < 8; k++)
            emit_branch(ACT_IF, 3'(k), 1'b1, 8'(40 + k));
        emit_op(ACT_POP, 4'd5, 4'd0);
        emit_op(ACT_RET, 4'd0, 4'd0);
        emit_branch(ACT_CALL, CMP_GT, 1'b0, 8'd90);
        emit_branch(ACT_CALL, CMP_GT, 1'b1, 8'd90);
        emit_op(ACT_RET, 4'd0, 4'd0);
        emit_op(ACT_PUSH, 4'd15, 4'd0);
        emit_op(ACT_POP, 4'd6, 4'd0);
        emit_op(ACT_LABEL, 4'd0, 4'd0);
        emit_op(4'd13, 4'd0, 4'd0);
        emit_op(4'd15, 4'd0, 4'd0);
        program_q[program_q.size() - 1].hold = 1'b1;

        // Random body, with one fill-the-stack sequence in the middle.
        for (int n = 0; n < 240; n++) begin
            if (n == 120) begin
                for (int k = 0; k < STACK_SLOTS + 2; k++)
                    emit_op(ACT_PUSH, 4'($urandom), 4'd0);
                emit_branch(ACT_CALL, CMP_GT, 1'b1, 8'd10);
                for (int k = 0; k < STACK_SLOTS + 2; k++)
                    emit_op(ACT_POP, 4'($urandom), 4'd0);
            end
            emit(random_instr());
        end

        // Finish on a division by zero, then show the machine stays halted.
        emit_mov(4'd7, 32'sd0);
        it = blank_instr(ACT_DIV);
        it.first_reg = 4'd1;
        it.second_reg = 4'd7;
        it.hold = 1'b1;
        emit(it, 1'b1);
        for (int k = 0; k < 4; k++)
            emit(random_instr(), 1'b1);
        stim_ready = 1'b1;
    end

    // ------------------------------------------------------------------
    // Reset
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: bursts of transfers separated by random gaps. A held item
    // waits until the block has returned every outstanding result.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (i_rst_n && stim_ready && n_accepted == n_issued) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (program_q.size() > 0 &&
                         !(program_q[0].hold && n_done != n_accepted)) begin
                i_action        <= program_q[0].action;
                i_first_reg     <= program_q[0].first_reg;
                i_second_reg    <= program_q[0].second_reg;
                i_first_is_imm  <= program_q[0].first_is_imm;
                i_first_imm     <= program_q[0].first_imm;
                i_second_is_imm <= program_q[0].second_is_imm;
                i_second_imm    <= program_q[0].second_imm;
                i_compare_kind  <= program_q[0].compare_kind;
                i_target_index  <= program_q[0].target_index;
                i_target_known  <= program_q[0].target_known;
                void'(program_q.pop_front());
                i_valid  <= 1'b1;
                n_issued <= n_issued + 1;
                // Start a new gap once the burst runs out.
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: stretches of no stall, light stall and heavy stall.
    // ------------------------------------------------------------------
    int stall_mode    = 0;
    int stretch_left  = 0;

    always @(negedge i_clk) begin
        if (stretch_left == 0) begin
            stall_mode   <= $urandom_range(0, 2);
            stretch_left <= $urandom_range(10, 80);
            i_stall      <= 1'b0;
        end else begin
            stretch_left <= stretch_left - 1;
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                default: i_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: count input transfers, check each result against the
    // oldest prediction, and watch for a hung block.
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        t_outcome want;
        bit       moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                n_accepted <= n_accepted + 1;
                moved = 1'b1;
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                if (n_done >= n_accepted || expected_q.size() == 0) begin
                    n_errors <= n_errors + 1;
                    if (n_errors < 10)
                        $display("unexpected result: next_index=%0d", o_next_index);
                end else begin
                    want = expected_q.pop_front();
                    n_done <= n_done + 1;
                    if (o_next_index !== want.next_index ||
                        o_print_value !== want.print_value ||
                        o_print_valid !== want.print_valid ||
                        o_div_zero_halt !== want.div_zero_halt ||
                        o_stack_full !== want.stack_full) begin
                        n_errors <= n_errors + 1;
                        if (n_errors < 10)
                            $display({"mismatch on result %0d: expected next=%0d pval=%0d ",
                                      "pvld=%0b halt=%0b full=%0b, got next=%0d pval=%0d ",
                                      "pvld=%0b halt=%0b full=%0b"},
                                     n_done, want.next_index, want.print_value,
                                     want.print_valid, want.div_zero_halt, want.stack_full,
                                     o_next_index, o_print_value, o_print_valid,
                                     o_div_zero_halt, o_stack_full);
                    end
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // End of run: wait for every transfer and result, then drain.
    // ------------------------------------------------------------------
    initial begin
        wait (stim_ready && program_q.size() == 0 && n_accepted == n_issued &&
              n_done == n_accepted);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
